// File: hw/rtl/stmc_pkg.sv
// Shared types and constants for the system timer compare channels block.
// Holds the operation codes, register map codes and the command and result
// words passed between the top level and the execute unit. No dependencies.
package stmc_pkg;

  // Operation codes carried by the input word
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_t;

  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;
  localparam int IRQ_W  = 4;
  localparam int CH_W   = 3;
  localparam int PSC_W  = 8;

  // Register map: base words and per-channel slots
  localparam logic [IDX_W-1:0] REG_CTRL  = 5'd0;
  localparam logic [IDX_W-1:0] REG_COUNT = 5'd1;
  localparam logic [1:0] SLOT_EN   = 2'd0;
  localparam logic [1:0] SLOT_FLAG = 2'd1;
  localparam logic [1:0] SLOT_CMP  = 2'd2;

  // Control word bit positions
  localparam int CTRL_TEN_BIT = 0;
  localparam int CTRL_FRZ_BIT = 1;
  localparam int CTRL_CSL_BIT = 4;
  localparam int CTRL_PSC_LSB = 8;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_lines;
  } res_t;

endpackage

// File: hw/rtl/stmc_exec.sv
// Execute unit: timer state, prescaler, counter and compare channels.
// Applies one command word per strobe and forms its result word.
// Depends on stmc_pkg.
module stmc_exec
  import stmc_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic exe_en,
  input  cmd_t cmd,
  output res_t res
);

  logic              ten_r, ten_nxt;
  logic              frz_r, frz_nxt;
  logic              csl_r, csl_nxt;
  logic [PSC_W-1:0]  psc_val_r, psc_val_nxt;
  logic [PSC_W-1:0]  psc_cnt_r, psc_cnt_nxt;
  logic [DATA_W-1:0] count_r, count_nxt;
  logic [DATA_W-1:0] count_inc;
  logic              en_r   [CHANNELS];
  logic              en_nxt [CHANNELS];
  logic              flag_r   [CHANNELS];
  logic              flag_nxt [CHANNELS];
  logic [DATA_W-1:0] cmp_r   [CHANNELS];
  logic [DATA_W-1:0] cmp_nxt [CHANNELS];

  opcode_t           op;
  logic [1:0]        slot;
  logic [CH_W-1:0]   ch;
  logic              ch_ok;
  logic [DATA_W-1:0] rd;
  logic [DATA_W-1:0] ch_rd;
  logic [IRQ_W-1:0]  irq;

  // Decode the word index into channel and slot
  assign op        = opcode_t'(cmd.opcode);
  assign slot      = cmd.reg_index[1:0];
  assign ch        = CH_W'(cmd.reg_index[4:2] - 3'd1);
  assign ch_ok     = (cmd.reg_index[4:2] != 3'd0) && ({1'b0, ch} < 4'(CHANNELS));
  assign count_inc = count_r + 32'd1;

  // Next state for ticks and writes
  always_comb begin
    ten_nxt     = ten_r;
    frz_nxt     = frz_r;
    csl_nxt     = csl_r;
    psc_val_nxt = psc_val_r;
    psc_cnt_nxt = psc_cnt_r;
    count_nxt   = count_r;
    for (int n = 0; n < CHANNELS; n++) begin
      en_nxt[n]   = en_r[n];
      flag_nxt[n] = flag_r[n];
      cmp_nxt[n]  = cmp_r[n];
    end
    case (op)
      OP_TICK: begin
        if (ten_r) begin
          if (psc_cnt_r >= psc_val_r) begin
            psc_cnt_nxt = '0;
            count_nxt   = count_inc;
            for (int n = 0; n < CHANNELS; n++) begin
              if (en_r[n] && (cmp_r[n] == count_inc)) flag_nxt[n] = 1'b1;
            end
          end else begin
            psc_cnt_nxt = psc_cnt_r + 8'd1;
          end
        end
      end
      OP_WRITE: begin
        if (cmd.reg_index == REG_CTRL) begin
          ten_nxt     = cmd.write_data[CTRL_TEN_BIT];
          frz_nxt     = cmd.write_data[CTRL_FRZ_BIT];
          csl_nxt     = cmd.write_data[CTRL_CSL_BIT];
          psc_val_nxt = cmd.write_data[CTRL_PSC_LSB +: PSC_W];
        end else if (cmd.reg_index == REG_COUNT) begin
          count_nxt = cmd.write_data;
        end else if (ch_ok) begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (ch == CH_W'(n)) begin
              case (slot)
                SLOT_EN:   en_nxt[n] = cmd.write_data[0];
                SLOT_FLAG: if (cmd.write_data[0]) flag_nxt[n] = 1'b0;
                SLOT_CMP:  cmp_nxt[n] = cmd.write_data;
                default:   ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Read mux over the current state
  always_comb begin
    ch_rd = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      if (ch == CH_W'(n)) begin
        case (slot)
          SLOT_EN:   ch_rd = {31'd0, en_r[n]};
          SLOT_FLAG: ch_rd = {31'd0, flag_r[n]};
          SLOT_CMP:  ch_rd = cmp_r[n];
          default:   ch_rd = '0;
        endcase
      end
    end
    rd = '0;
    if (op == OP_READ) begin
      if (cmd.reg_index == REG_CTRL) begin
        rd[CTRL_TEN_BIT]               = ten_r;
        rd[CTRL_FRZ_BIT]               = frz_r;
        rd[CTRL_CSL_BIT]               = csl_r;
        rd[CTRL_PSC_LSB +: PSC_W]      = psc_val_r;
      end else if (cmd.reg_index == REG_COUNT) begin
        rd = count_r;
      end else if (ch_ok) begin
        rd = ch_rd;
      end
    end
  end

  // Interrupt lines sampled after this word's effect
  always_comb begin
    irq = '0;
    for (int n = 0; n < CHANNELS && n < IRQ_W; n++) begin
      irq[n] = flag_nxt[n] & en_nxt[n];
    end
  end

  assign res.read_data = rd;
  assign res.irq_lines = irq;

  // Commit state on each executed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ten_r     <= 1'b0;
      frz_r     <= 1'b0;
      csl_r     <= 1'b0;
      psc_val_r <= '0;
      psc_cnt_r <= '0;
      count_r   <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        en_r[n]   <= 1'b0;
        flag_r[n] <= 1'b0;
        cmp_r[n]  <= '0;
      end
    end else if (exe_en) begin
      ten_r     <= ten_nxt;
      frz_r     <= frz_nxt;
      csl_r     <= csl_nxt;
      psc_val_r <= psc_val_nxt;
      psc_cnt_r <= psc_cnt_nxt;
      count_r   <= count_nxt;
      for (int n = 0; n < CHANNELS; n++) begin
        en_r[n]   <= en_nxt[n];
        flag_r[n] <= flag_nxt[n];
        cmp_r[n]  <= cmp_nxt[n];
      end
    end
  end

endmodule

// File: hw/rtl/system_timer_compare_channels_core.sv
// System timer with a 32-bit wrapping counter, 8-bit prescaler and compare
// channels. Every input word is a clock tick, a register read or a register
// write; every input word yields exactly one result word.
//
// Input channel: in_valid/in_ready with in_opcode, in_reg_index, in_write_data.
// Result channel: out_valid/out_ready with out_read_data (register contents
// for reads, zero otherwise) and out_irq_lines (enabled flags after the word).
//
// Path: a word passes through the input register and then the result register,
// from which out_* shows its result word until it is taken. Throughput: one
// word per cycle, limited only by the result register being taken.
//
// When the receiver stalls, the result register holds and the input register
// holds its word, so in_ready drops once both are full. Words are executed in
// order and state changes only when a word moves into the result register.
//
// Reset (synchronous, rst_n low) clears both pipeline valids and all timer
// state: control, prescaler, counter, enables, flags and compare words.
// Depends on stmc_pkg and stmc_exec.
module system_timer_compare_channels_core
  import stmc_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [IDX_W-1:0]    in_reg_index,
  input  logic [DATA_W-1:0]   in_write_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [IRQ_W-1:0]    out_irq_lines
);

  logic s1_valid_r;
  cmd_t s1_cmd_r;
  logic out_valid_r;
  res_t out_res_r;
  res_t exe_res;
  logic adv;
  logic exe_fire;

  // Advance the pipeline when the result register is free or being taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign exe_fire = s1_valid_r && adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r.opcode     <= in_opcode;
      s1_cmd_r.reg_index  <= in_reg_index;
      s1_cmd_r.write_data <= in_write_data;
    end
  end

  stmc_exec #(
    .CHANNELS(CHANNELS)
  ) u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .exe_en (exe_fire),
    .cmd    (s1_cmd_r),
    .res    (exe_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exe_fire) begin
      out_res_r <= exe_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_res_r.read_data;
  assign out_irq_lines = out_res_r.irq_lines;

endmodule

// File: hw/rtl/stmc_checker.sv
// Port-level checker for the system timer compare channels core, with the
// bind that attaches it to the top level. Depends on stmc_pkg.
module stmc_checker
  import stmc_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_data,
  input logic [IRQ_W-1:0]  out_irq_lines
);

  localparam int IRQ_USED = (CHANNELS < IRQ_W) ? CHANNELS : IRQ_W;
  localparam logic [IRQ_W-1:0] IRQ_MASK = IRQ_W'((1 << IRQ_USED) - 1);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
                                $stable(out_irq_lines))
    else $error("stalled result word changed");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Accept a word whenever the result side is not stalled
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !out_ready) |-> in_ready)
    else $error("input stalled while result side free");

  // Only implemented channels drive interrupt lines
  a_irq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_irq_lines & ~IRQ_MASK) == '0)
    else $error("interrupt line of missing channel set");

  // A result can only follow an accepted word
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2) ||
                                       $past(!in_ready, 2))
    else $error("result word without input word");

endmodule

bind system_timer_compare_channels_core stmc_checker #(
  .CHANNELS(CHANNELS)
) u_stmc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data),
  .out_irq_lines (out_irq_lines)
);
